>>> design/plni_pkg.sv
// Shared types and constants for the piecewise linear interpolator.
package plni_pkg;

  localparam int DATA_W = 32;
  localparam int CFG_W  = 7;
  localparam int IDXF_W = 6;
  localparam int STAT_W = 2;
  localparam int DIV_STEP_W = $clog2(DATA_W);

  localparam logic [CFG_W-1:0]  KNOT_COUNT_RST = 7'd2;
  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_INSIDE = 2'd0,
    ST_LOW    = 2'd1,
    ST_HIGH   = 2'd2,
    ST_NONE   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_SCAN,
    S_PREP,
    S_MUL,
    S_DIV,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
  } knot_t;

endpackage

>>> design/piecewise_linear_interpolator_unit.sv
// Piecewise linear interpolator with clamping: top level, sequencer and datapath.
//
// Input channel (in_valid / in_stall): a beat with in_func = load writes the knot
// (in_coordinate, in_knot_value) at in_knot_index and returns nothing. A beat with
// in_func = query evaluates the table at in_coordinate and
// returns one beat on the output channel (out_valid / out_stall).
// Configuration: cfg_wr_en with cfg_wr_data sets knot_count, the number of knots
// in use from index zero. Write it only while the block is idle.
// Query steps: compare with the first knot (clamped low), then with the last
// (clamped high), then scan for the segment, one knot read per cycle from the
// single table port, then a multiply and a serial divide for a hit. One query
// is in flight at a time; in_stall is high while it runs.
// The result sits in an output register, so a new beat is accepted while the
// previous result waits for the receiver. If the receiver stalls and a second
// result is ready, the sequencer holds it until the output register drains.
// Reset (rst_n low, synchronous): sequencer idle, output empty, knot_count = 2.
// The knot table is not cleared; load every knot in use before querying.
module piecewise_linear_interpolator_unit #(
  parameter int MAX_KNOTS = 64,
  localparam int IDX_W = $clog2(MAX_KNOTS)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [plni_pkg::CFG_W-1:0]          cfg_wr_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_func,
  input  logic [plni_pkg::IDXF_W-1:0]         in_knot_index,
  input  logic signed [plni_pkg::DATA_W-1:0]  in_coordinate,
  input  logic signed [plni_pkg::DATA_W-1:0]  in_knot_value,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [plni_pkg::DATA_W-1:0]  out_interpolated,
  output logic [plni_pkg::STAT_W-1:0]         out_status
);
  import plni_pkg::*;

  // wide enough for any count, index or their sum
  localparam int CW = IDX_W + 8;

  fsm_t state_r, state_nxt;

  logic [CFG_W-1:0]         knot_count_r, knot_count_nxt;
  logic signed [DATA_W-1:0] q_r, q_nxt;
  logic signed [DATA_W-1:0] px_r, px_nxt, py_r, py_nxt;
  logic signed [DATA_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [DATA_W-1:0]        dx_r, dx_nxt, dq_r, dq_nxt, mag_r, mag_nxt;
  logic                     neg_r, neg_nxt;
  logic [IDX_W-1:0]         j_r, j_nxt;
  logic [DATA_W-1:0]        res_r, res_nxt;
  status_t                  stat_r, stat_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]        out_val_r, out_val_nxt;
  status_t                  out_stat_r, out_stat_nxt;

  logic              in_accept;
  logic [CW-1:0]     idx_w, cnt_w, n_w, next_w;
  logic              wr_ok;
  logic [IDX_W-1:0]  rd_addr, last_addr;
  knot_t             rd_knot, wr_knot;
  logic              q_le_rd, q_ge_rd, seg_hit, scan_end, out_free;
  logic [DATA_W:0]   dx_w, dq_w, dy_w, dy_abs;
  logic              dx_zero;
  logic              div_start, div_done;
  logic [DATA_W-1:0] quo;
  logic [DATA_W+1:0] quo_s, sum_w;
  logic [DATA_W-1:0] sat_w;

  assign in_accept = in_valid && !in_stall;

  // drop loads beyond the table; clamp the count to one .. MAX_KNOTS
  assign idx_w  = CW'(in_knot_index);
  assign wr_ok  = idx_w < CW'(MAX_KNOTS);
  assign cnt_w  = CW'(knot_count_r);
  assign n_w    = (cnt_w == '0) ? CW'(1) :
                  (cnt_w > CW'(MAX_KNOTS)) ? CW'(MAX_KNOTS) : cnt_w;
  assign last_addr = IDX_W'(n_w - CW'(1));
  assign next_w    = CW'(j_r) + CW'(2);

  assign wr_knot.x = in_coordinate;
  assign wr_knot.y = in_knot_value;

  plni_knot_ram #(.DEPTH(MAX_KNOTS)) u_ram (
    .clk     (clk),
    .wr_en   (in_accept && (in_func == FUNC_LOAD) && wr_ok),
    .wr_addr (idx_w[IDX_W-1:0]),
    .wr_data (wr_knot),
    .rd_addr (rd_addr),
    .rd_data (rd_knot)
  );

  // compares against the knot read last cycle
  assign q_le_rd  = q_r <= rd_knot.x;
  assign q_ge_rd  = q_r >= rd_knot.x;
  assign seg_hit  = (px_r <= q_r) && q_le_rd;
  assign scan_end = next_w == n_w;
  assign out_free = !out_valid_r || !out_stall;

  // segment set-up: widths, offset and magnitude of the rise
  assign dx_w    = {cx_r[DATA_W-1], cx_r} - {px_r[DATA_W-1], px_r};
  assign dq_w    = {q_r[DATA_W-1], q_r} - {px_r[DATA_W-1], px_r};
  assign dy_w    = {cy_r[DATA_W-1], cy_r} - {py_r[DATA_W-1], py_r};
  assign dy_abs  = dy_w[DATA_W] ? ((DATA_W+1)'(0) - dy_w) : dy_w;
  assign dx_zero = dx_w[DATA_W-1:0] == '0;

  plni_serial_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag_r * dq_r),
    .divisor  (dx_r),
    .quotient (quo),
    .done     (div_done)
  );

  // add the signed step to y0 and saturate to 32 bits
  assign quo_s = neg_r ? ((DATA_W+2)'(0) - {2'b00, quo}) : {2'b00, quo};
  assign sum_w = {{2{py_r[DATA_W-1]}}, py_r} + quo_s;
  assign sat_w = (sum_w[DATA_W+1:DATA_W-1] == 3'b000 || sum_w[DATA_W+1:DATA_W-1] == 3'b111)
                 ? sum_w[DATA_W-1:0] : (sum_w[DATA_W+1] ? SAT_MIN : SAT_MAX);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_accept && (in_func == FUNC_QUERY)) state_nxt = S_FIRST;
      S_FIRST: state_nxt = q_le_rd ? S_DONE : S_LAST;
      S_LAST:  state_nxt = q_ge_rd ? S_DONE : S_SCAN;
      S_SCAN: begin
        priority if (seg_hit) state_nxt = S_PREP;
        else if (scan_end) state_nxt = S_DONE;
        else state_nxt = S_SCAN;
      end
      S_PREP:  state_nxt = dx_zero ? S_DONE : S_MUL;
      S_MUL:   state_nxt = S_DIV;
      S_DIV:   if (div_done) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs: stall, table read address, divider start
  always_comb begin
    in_stall  = 1'b1;
    rd_addr   = '0;
    div_start = 1'b0;
    unique case (state_r)
      S_IDLE:  in_stall = 1'b0;
      S_FIRST: rd_addr = last_addr;
      S_LAST:  rd_addr = IDX_W'(1);
      S_SCAN:  rd_addr = next_w[IDX_W-1:0];
      S_MUL:   div_start = 1'b1;
      S_PREP, S_DIV, S_DONE: rd_addr = '0;
      default: rd_addr = '0;
    endcase
  end

  // datapath
  always_comb begin
    knot_count_nxt = cfg_wr_en ? cfg_wr_data : knot_count_r;
    q_nxt   = q_r;
    px_nxt  = px_r;
    py_nxt  = py_r;
    cx_nxt  = cx_r;
    cy_nxt  = cy_r;
    dx_nxt  = dx_r;
    dq_nxt  = dq_r;
    mag_nxt = mag_r;
    neg_nxt = neg_r;
    j_nxt   = j_r;
    res_nxt = res_r;
    stat_nxt = stat_r;
    out_val_nxt  = out_val_r;
    out_stat_nxt = out_stat_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) q_nxt = in_coordinate;
      end
      S_FIRST: begin
        if (q_le_rd) begin
          res_nxt  = rd_knot.y;
          stat_nxt = ST_LOW;
        end else begin
          px_nxt = rd_knot.x;
          py_nxt = rd_knot.y;
        end
      end
      S_LAST: begin
        res_nxt  = rd_knot.y;
        stat_nxt = ST_HIGH;
        j_nxt    = '0;
      end
      S_SCAN: begin
        priority if (seg_hit) begin
          cx_nxt = rd_knot.x;
          cy_nxt = rd_knot.y;
        end else if (scan_end) begin
          res_nxt  = '0;
          stat_nxt = ST_NONE;
        end else begin
          // advance: this knot becomes the segment start
          px_nxt = rd_knot.x;
          py_nxt = rd_knot.y;
          j_nxt  = j_r + 1'b1;
        end
      end
      S_PREP: begin
        dx_nxt  = dx_w[DATA_W-1:0];
        dq_nxt  = dq_w[DATA_W-1:0];
        mag_nxt = dy_abs[DATA_W-1:0];
        neg_nxt = dy_w[DATA_W];
        res_nxt  = py_r;
        stat_nxt = ST_INSIDE;
      end
      S_MUL: begin
        stat_nxt = ST_INSIDE;
      end
      S_DIV: begin
        if (div_done) res_nxt = sat_w;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_r;
          out_stat_nxt  = stat_r;
        end
      end
      default: res_nxt = res_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      knot_count_r <= KNOT_COUNT_RST;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      knot_count_r <= knot_count_nxt;
    end
    q_r   <= q_nxt;
    px_r  <= px_nxt;
    py_r  <= py_nxt;
    cx_r  <= cx_nxt;
    cy_r  <= cy_nxt;
    dx_r  <= dx_nxt;
    dq_r  <= dq_nxt;
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
    j_r   <= j_nxt;
    res_r <= res_nxt;
    stat_r <= stat_nxt;
    out_val_r  <= out_val_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_interpolated = out_val_r;
  assign out_status       = out_stat_r;

`ifndef SYNTHESIS
  // a query beat starts the table scan on the next cycle
  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_func == FUNC_QUERY) |=> state_r == S_FIRST)
    else $error("query beat did not start the scan");

  // the divider finishes only while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside the divide state");

  // inside a matched segment the offset never exceeds the width
  a_offset_in_segment: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL |-> dq_r <= dx_r)
    else $error("segment offset exceeds segment width");

  // the scan's next read address never exceeds the knot count in use
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> next_w <= n_w)
    else $error("scan ran past the last knot");
`endif

endmodule

>>> design/plni_knot_ram.sv
// Knot table: one write port, one registered read port.
module plni_knot_ram #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  plni_pkg::knot_t wr_data,
  input  logic [AW-1:0]   rd_addr,
  output plni_pkg::knot_t rd_data
);
  import plni_pkg::*;

  knot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> design/plni_serial_div.sv
// Restoring divider, one quotient bit per cycle; quotient known to fit DATA_W bits.
module plni_serial_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [2*plni_pkg::DATA_W-1:0]    dividend,
  input  logic [plni_pkg::DATA_W-1:0]      divisor,
  output logic [plni_pkg::DATA_W-1:0]      quotient,
  output logic                             done
);
  import plni_pkg::*;

  logic [DATA_W-1:0]     rem_r, rem_nxt;
  logic [DATA_W-1:0]     lo_r, lo_nxt;
  logic [DIV_STEP_W-1:0] cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DATA_W:0]       trial;
  logic [DATA_W:0]       diff;
  logic                  ge;

  assign trial = {rem_r, lo_r[DATA_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = dividend[2*DATA_W-1:DATA_W];
      lo_nxt   = dividend[DATA_W-1:0];
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract where it fits
      rem_nxt = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      lo_nxt  = {lo_r[DATA_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_STEP_W'(DATA_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
  end

  assign quotient = lo_r;
  assign done     = done_r;

endmodule

>>> test/piecewise_linear_interpolator_unit_checker.sv
`timescale 1ns / 100ps
// Checker for the interpolator: predicts every query beat and compares the output beats.
module piecewise_linear_interpolator_unit_checker #(
  parameter int MAX_KNOTS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [plni_pkg::CFG_W-1:0]          cfg_wr_data,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                in_func,
  input  logic [plni_pkg::IDXF_W-1:0]         in_knot_index,
  input  logic signed [plni_pkg::DATA_W-1:0]  in_coordinate,
  input  logic signed [plni_pkg::DATA_W-1:0]  in_knot_value,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [plni_pkg::DATA_W-1:0]  out_interpolated,
  input  logic [plni_pkg::STAT_W-1:0]         out_status,
  input  logic                                run_over,
  output int                                  mismatches,
  output int                                  pending,
  output int                                  results_checked,
  output int                                  loads_seen,
  output int                                  queries_seen
);
  import plni_pkg::*;

  localparam int     MAX_REPORTS = 40;
  localparam longint Y_MAX = 64'sd2147483647;
  localparam longint Y_MIN = -64'sd2147483648;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    status_t                  status;
  } interp_result_t;

  logic signed [DATA_W-1:0] table_x [MAX_KNOTS];
  logic signed [DATA_W-1:0] table_y [MAX_KNOTS];
  logic [CFG_W-1:0]         count_reg = KNOT_COUNT_RST;
  interp_result_t           awaited_interp [$];
  int                       fail_tally = 0;
  int                       checked_tally = 0;
  int                       load_tally = 0;
  int                       query_tally = 0;
  bit                       leftovers_done = 1'b0;

  task automatic report_mismatch(input string what);
    if (fail_tally < MAX_REPORTS)
      $display("[%0t] mismatch: %s", $time, what);
    fail_tally++;
  endtask

  function automatic interp_result_t predict_interpolation(
    input logic signed [DATA_W-1:0] q
  );
    interp_result_t       r;
    int                   n;
    int                   j;
    bit                   found;
    longint               x0, x1, y0, dy, sum;
    longint unsigned      dx, dq, mag, quot;
    r.value  = '0;
    r.status = ST_NONE;
    found    = 1'b0;
    n = (count_reg == 0) ? 1 : ((count_reg > MAX_KNOTS) ? MAX_KNOTS : int'(count_reg));
    if (q <= table_x[0]) begin
      r.value  = table_y[0];
      r.status = ST_LOW;
    end else if (q >= table_x[n-1]) begin
      r.value  = table_y[n-1];
      r.status = ST_HIGH;
    end else begin
      // first segment that brackets q wins, sorted or not
      for (j = 0; j + 1 < n && !found; j++) begin
        if (table_x[j] <= q && q <= table_x[j+1]) begin
          found = 1'b1;
          x0 = table_x[j];
          x1 = table_x[j+1];
          y0 = table_y[j];
          dy = longint'(table_y[j+1]) - y0;
          dx = longint'(x1 - x0);
          dq = longint'(longint'(q) - x0);
          if (dx == 0) begin
            sum = y0;
          end else begin
            mag  = (dy < 0) ? longint'(-dy) : longint'(dy);
            quot = (mag * dq) / dx;
            sum  = (dy < 0) ? y0 - longint'(quot) : y0 + longint'(quot);
          end
          if (sum > Y_MAX) sum = Y_MAX;
          if (sum < Y_MIN) sum = Y_MIN;
          r.value  = sum[DATA_W-1:0];
          r.status = ST_INSIDE;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    interp_result_t want;
    if (!rst_n) begin
      awaited_interp.delete();
      count_reg = KNOT_COUNT_RST;
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (awaited_interp.size() == 0) begin
          report_mismatch($sformatf("result %0d status %0d with no query outstanding",
                                    out_interpolated, out_status));
        end else begin
          want = awaited_interp.pop_front();
          if (out_interpolated !== want.value)
            report_mismatch($sformatf("interpolated %0d, predicted %0d",
                                      out_interpolated, want.value));
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, predicted %s",
                                      out_status, want.status.name()));
          checked_tally++;
        end
      end
      if (cfg_wr_en)
        count_reg = cfg_wr_data;
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        if (in_func == FUNC_LOAD) begin
          if (in_knot_index < MAX_KNOTS) begin
            table_x[in_knot_index] = in_coordinate;
            table_y[in_knot_index] = in_knot_value;
          end
          load_tally++;
        end else begin
          awaited_interp.push_back(predict_interpolation(in_coordinate));
          query_tally++;
        end
      end
      if (run_over && !leftovers_done) begin
        leftovers_done = 1'b1;
        if (awaited_interp.size() != 0)
          report_mismatch($sformatf("%0d results never arrived", awaited_interp.size()));
      end
    end
    mismatches      <= fail_tally;
    pending         <= awaited_interp.size();
    results_checked <= checked_tally;
    loads_seen      <= load_tally;
    queries_seen    <= query_tally;
  end

endmodule

>>> test/piecewise_linear_interpolator_unit_test.sv
`timescale 1ns / 100ps
// Testbench top for the interpolator: stimulus, channel pacing and the verdict.
module piecewise_linear_interpolator_unit_test;
  import plni_pkg::*;

  localparam int     KNOTS           = 64;
  localparam int     HOLD_OFF_CYCLES = 300;  // long receiver hold-off
  localparam int     SETTLE_CYCLES   = 120;  // worst query latency plus margin
  localparam int     DRAIN_LIMIT     = 20000;
  localparam int     PHASES          = 15;
  localparam int     PRESSURE_PHASE  = 2;
  localparam longint X_LOW           = -64'sd2147483648;
  localparam longint FULL_RANGE      = 64'sd4294967295;

  // table shapes for the random phases
  localparam int SHAPE_ASCEND    = 0;
  localparam int SHAPE_DUPS      = 1;
  localparam int SHAPE_SCRAMBLED = 2;
  localparam int SHAPE_FULL_SPAN = 3;
  localparam int SHAPE_DESCEND   = 4;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_wr_en;
  logic [CFG_W-1:0]          cfg_wr_data;
  logic                      in_valid;
  logic                      in_stall;
  logic                      in_func;
  logic [IDXF_W-1:0]         in_knot_index;
  logic signed [DATA_W-1:0]  in_coordinate;
  logic signed [DATA_W-1:0]  in_knot_value;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [DATA_W-1:0]  out_interpolated;
  logic [STAT_W-1:0]         out_status;
  logic                      run_over;

  int mismatches;
  int pending;
  int results_checked;
  int loads_seen;
  int queries_seen;

  // stimulus-side view of the table, used only to aim queries
  logic signed [DATA_W-1:0] shadow_x [KNOTS];
  int  knot_span = 2;
  int  tx_mode = 1;        // 0: back-to-back beats, otherwise bursts with gaps
  int  rx_mode = 1;        // 0: never stall, 1: light stalls, 2: heavy stalls
  int  burst_left = 0;
  bit  hold_off_req = 1'b0;
  int  refused_cycles = 0;
  int  phase_knots [PHASES];
  int  phase_queries [PHASES];

  always #5 clk = ~clk;

  piecewise_linear_interpolator_unit #(.MAX_KNOTS(KNOTS)) dut (.*);

  piecewise_linear_interpolator_unit_checker #(.MAX_KNOTS(KNOTS)) watcher (.*);

  // Count cycles in which the block refused an offered beat.
  always @(posedge clk)
    if (in_valid === 1'b1 && in_stall === 1'b1) refused_cycles++;

  // Receiver: stall in runs of random length; on request, hold off for a long
  // stretch so the output register and the sequencer both fill up.
  initial begin : receiver
    int run_len;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        run_len = $urandom_range(1, 12);
        case (rx_mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            out_stall <= ($urandom_range(0, 1) == 0);
          end
        endcase
        repeat (run_len) @(posedge clk);
      end
    end
  end

  // Timeout: end the run if it goes far beyond the slowest legal run.
  initial begin : watchdog
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic longint unsigned rand_upto(input longint unsigned limit_val);
    longint unsigned r;
    r = {$urandom, $urandom};
    return r % (limit_val + 1);
  endfunction

  function automatic int span_of(input int count);
    return (count == 0) ? 1 : ((count > KNOTS) ? KNOTS : count);
  endfunction

  // Offer one beat and hold it until accepted, then advance the burst pacing.
  // Valid stays high into the next beat unless a gap follows.
  task automatic offer_beat(input logic func, input logic [IDXF_W-1:0] idx,
                            input logic signed [DATA_W-1:0] coord,
                            input logic signed [DATA_W-1:0] val);
    int gap;
    in_valid      <= 1'b1;
    in_func       <= func;
    in_knot_index <= idx;
    in_coordinate <= coord;
    in_knot_value <= val;
    do @(posedge clk); while (in_stall !== 1'b0);
    gap = 0;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (tx_mode != 0) gap = $urandom_range(1, 10);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_knot(input int idx, input logic signed [DATA_W-1:0] x,
                           input logic signed [DATA_W-1:0] y);
    shadow_x[idx] = x;
    offer_beat(FUNC_LOAD, IDXF_W'(idx), x, y);
  endtask

  // The knot value is ignored on a query, so randomise it.
  task automatic query_at(input logic signed [DATA_W-1:0] q);
    offer_beat(FUNC_QUERY, IDXF_W'($urandom_range(0, KNOTS - 1)), q, $urandom);
  endtask

  // Drop valid, wait for every outstanding result, then let a query that may
  // still be in flight finish before touching the register.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_knot_count(input int count);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CFG_W'(count);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    knot_span = span_of(count);
  endtask

  // Load knots 0 .. span-1 as one table: mostly ascending with random strides,
  // sometimes with repeated x, scrambled, pinned to the extremes or descending.
  task automatic build_table(input int shape);
    logic signed [DATA_W-1:0] xs [KNOTS];
    logic signed [DATA_W-1:0] y;
    longint                   pos, cap, per;
    int                       n, i, y_mode;
    n      = knot_span;
    y_mode = $urandom_range(0, 3);
    per    = (n > 1) ? FULL_RANGE / (n - 1) : FULL_RANGE;
    cap    = longint'(1) << $urandom_range(0, 32);
    if (cap > per) cap = per;
    pos    = X_LOW + longint'(rand_upto(FULL_RANGE - (n - 1) * cap));
    for (i = 0; i < n; i++) begin
      if (i > 0) begin
        if (shape == SHAPE_DUPS && $urandom_range(0, 2) == 0)
          pos = pos;
        else
          pos = pos + 1 + longint'(rand_upto(cap - 1));
      end
      xs[i] = (shape == SHAPE_SCRAMBLED) ? DATA_W'($urandom) : pos[DATA_W-1:0];
    end
    if (shape == SHAPE_FULL_SPAN && n > 1) begin
      xs[0]   = SAT_MIN;
      xs[n-1] = SAT_MAX;
    end
    for (i = 0; i < n; i++) begin
      case (y_mode)
        2: y = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
        3: y = $urandom_range(0, 1) ? SAT_MAX : SAT_MIN;
        default: y = $urandom;
      endcase
      load_knot((shape == SHAPE_DESCEND) ? n - 1 - i : i, xs[i], y);
    end
  endtask

  // Aim mostly between the end knots, with some hits on knots, their
  // neighbours, and the whole coordinate range.
  function automatic logic signed [DATA_W-1:0] pick_query_coord();
    longint lo, hi, tmp;
    int     k;
    lo = shadow_x[0];
    hi = shadow_x[knot_span - 1];
    if (lo > hi) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    k = $urandom_range(0, knot_span - 1);
    case ($urandom_range(0, 9))
      0, 1:    return $urandom;
      2:       return shadow_x[k];
      3:       return shadow_x[k] + ($urandom_range(0, 1) ? 1 : -1);
      default: return DATA_W'(lo + longint'(rand_upto(hi - lo)));
    endcase
  endfunction

  initial begin : stimulus
    int p, i, w, shape_pick;
    rst_n         <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= KNOT_COUNT_RST;
    in_valid      <= 1'b0;
    in_func       <= FUNC_LOAD;
    in_knot_index <= '0;
    in_coordinate <= '0;
    in_knot_value <= '0;
    run_over      <= 1'b0;
    phase_knots   = '{5, 64, 2, 17, 127, 1, 9, 0, 33, 3, 65, 6, 12, 4, 2};
    phase_queries = '{70, 15, 70, 50, 12, 30, 70, 30, 25, 70, 12, 70, 60, 70, 50};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: two knots at the coordinate extremes with opposite extreme y,
    // giving the widest product and quotient the datapath can see.
    load_knot(0, SAT_MIN, SAT_MAX);
    load_knot(1, SAT_MAX, SAT_MIN);
    query_at(SAT_MIN);
    query_at(SAT_MAX);
    query_at(0);
    query_at(-1);
    query_at(1);
    query_at(SAT_MIN + 1);
    query_at(SAT_MAX - 1);
    // A count of zero behaves as a single knot: everything clamps.
    write_knot_count(0);
    query_at(SAT_MIN);
    query_at(SAT_MIN + 1);
    write_knot_count(1);
    query_at(0);
    // Three knots out of order: 0, 1.0, 0.5.
    write_knot_count(3);
    load_knot(0, 0, 32'sh0001_0000);
    load_knot(1, 32'sh0001_0000, -32'sh0003_0000);
    load_knot(2, 32'sh0000_8000, 7);
    query_at(32'sh0000_4000);
    query_at(32'sh0000_8000);
    query_at(32'sh0000_9000);
    query_at(32'sh0000_FFFF);

    // Random phases: new count, fresh table, then mostly queries with a few
    // stray reloads. Counts above the table size and zero are in the list.
    for (p = 0; p < PHASES; p++) begin
      write_knot_count(phase_knots[p]);
      tx_mode = (p == 0 || p == PRESSURE_PHASE || $urandom_range(0, 3) == 0) ? 0 : 1;
      rx_mode = (p == 0) ? 0 : $urandom_range(0, 2);
      shape_pick = $urandom_range(0, 9);
      case (shape_pick)
        6:       build_table(SHAPE_DUPS);
        7:       build_table(SHAPE_SCRAMBLED);
        8:       build_table(SHAPE_FULL_SPAN);
        9:       build_table(SHAPE_DESCEND);
        default: build_table(SHAPE_ASCEND);
      endcase
      if (p == PRESSURE_PHASE) hold_off_req = 1'b1;
      for (i = 0; i < phase_queries[p]; i++) begin
        case ($urandom_range(0, 15))
          0:       load_knot($urandom_range(0, knot_span - 1), $urandom, $urandom);
          1:       load_knot($urandom_range(0, KNOTS - 1), $urandom, $urandom);
          default: query_at(pick_query_coord());
        endcase
      end
    end

    // Drain: wait for every result, then a little longer, then close the books.
    in_valid <= 1'b0;
    for (w = 0; w < DRAIN_LIMIT && pending != 0; w++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    run_over <= 1'b1;
    repeat (2) @(posedge clk);
    $display("covered %0d knot loads and %0d queries; %0d results compared",
             loads_seen, queries_seen, results_checked);
    $display("knot counts 0 to 127 incl. a full table; input refused for %0d cycles",
             refused_cycles);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
